// ----- rtl/core/est_pkg.sv -----
// Shared types for the exchange sort core: controller states and cell control.
package est_pkg;

    localparam int unsigned KEY_W = 32;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               load;
        logic               drain;
        logic [KEY_W-1:0]   key;
    } t_cell_ctl;

endpackage

// ----- rtl/core/est_cell.sv -----
// One sorting cell: holds a key, inserts by shifting right, drains by shifting left.
module est_cell
    import est_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_W-1:0]    i_left_key,
    input  logic                i_left_valid,
    input  logic                i_left_above,
    input  logic [KEY_W-1:0]    i_right_key,
    input  logic                i_right_valid,
    output logic [KEY_W-1:0]    o_key,
    output logic                o_valid,
    output logic                o_above
);

    logic [KEY_W-1:0]   r_key;
    logic               r_valid;
    logic [KEY_W-1:0]   n_key;
    logic               n_valid;

    assign o_above = !r_valid || ($signed(r_key) > $signed(i_ctl.key));
    assign o_key   = r_key;
    assign o_valid = r_valid;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.drain) begin
            n_key   = i_right_key;
            n_valid = i_right_valid;
        end else if (i_ctl.load && o_above) begin
            if (i_left_above) begin
                n_key   = i_left_key;
                n_valid = i_left_valid;
            end else begin
                n_key   = i_ctl.key;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
    end

endmodule

// ----- rtl/core/exchange_sort_integers_core.sv -----
// Top level of the exchange sort core: cell chain and load/emit controller.
// Output: the first sorted item is offered in the cycle after the last input item is taken.
// Throughput: one input item per cycle while loading, one result per cycle while
// emitting and not stalled; the input is stalled while a set drains out of the
// cell chain through cell zero.
// Reset: synchronous active low; clears all cell valid bits, the overflow flag and state.
module exchange_sort_integers_core
    import est_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [31:0]      i_value,
    input  logic                    i_last_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [31:0]      o_sorted_value,
    output logic                    o_last_out,
    output logic                    o_overflowed
);

    t_state             r_state;
    t_state             n_state;
    logic               r_ovf;
    logic               n_ovf;
    t_cell_ctl          w_ctl;
    logic               w_in_acc;
    logic               w_out_acc;

    logic [KEY_W-1:0]   w_key   [MAX_ITEMS];
    logic               w_valid [MAX_ITEMS];
    logic               w_above [MAX_ITEMS];

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic [KEY_W-1:0]   w_lkey;
        logic               w_lvalid;
        logic               w_labove;
        logic [KEY_W-1:0]   w_rkey;
        logic               w_rvalid;

        if (g == 0) begin : g_first
            assign w_lkey   = '0;
            assign w_lvalid = 1'b0;
            assign w_labove = 1'b0;
        end else begin : g_mid
            assign w_lkey   = w_key[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_labove = w_above[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_last
            assign w_rkey   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_inner
            assign w_rkey   = w_key[g+1];
            assign w_rvalid = w_valid[g+1];
        end

        est_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_key    (w_lkey),
            .i_left_valid  (w_lvalid),
            .i_left_above  (w_labove),
            .i_right_key   (w_rkey),
            .i_right_valid (w_rvalid),
            .o_key         (w_key[g]),
            .o_valid       (w_valid[g]),
            .o_above       (w_above[g])
        );
    end

    always_comb begin
        w_in_acc  = i_valid && (r_state == ST_LOAD);
        w_out_acc = (r_state == ST_EMIT) && w_valid[0] && !i_stall;

        w_ctl.load  = w_in_acc && !w_valid[MAX_ITEMS-1];
        w_ctl.drain = w_out_acc;
        w_ctl.key   = i_value;

        n_ovf = r_ovf;
        if (w_out_acc && !w_valid[1]) begin
            n_ovf = 1'b0;
        end else if (w_in_acc && w_valid[MAX_ITEMS-1]) begin
            n_ovf = 1'b1;
        end

        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_last_in) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc && !w_valid[1]) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    assign o_stall        = (r_state != ST_LOAD);
    assign o_valid        = (r_state == ST_EMIT) && w_valid[0];
    assign o_sorted_value = $signed(w_key[0]);
    assign o_last_out     = !w_valid[1];
    assign o_overflowed   = r_ovf;

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_valid[0] && ($signed(w_key[0]) <= $signed(w_key[1]))))
        else $error("cell chain head out of order");

    a_emit_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_in) |=> o_valid)
        else $error("no result after last item");

    a_empty_after_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_out) |=> (!o_stall && !w_valid[0] && !o_overflowed))
        else $error("chain not empty after set");

    a_overflow_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && w_valid[MAX_ITEMS-1]) |=> o_overflowed)
        else $error("dropped item not flagged");

endmodule

// ----- verif/tb_exchange_sort_integers_core.sv -----
// Testbench for exchange_sort_integers_core: sorted sets checked against a predicted key order.
module tb_exchange_sort_integers_core
    import est_pkg::*;
();

    localparam int unsigned MAX_ITEMS   = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_LEN    = 400;
    localparam int unsigned TAIL_CYCLES = 20;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic                    ovf;
    } t_sorted_item;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [KEY_W-1:0] in_value;
    logic                    in_last;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [KEY_W-1:0] out_value;
    logic                    out_last;
    logic                    out_ovf;

    logic signed [KEY_W-1:0] key_store [MAX_ITEMS];
    int unsigned             key_count;
    logic                    key_dropped;
    t_sorted_item            sorted_q [$];

    int unsigned             fail_count;
    int unsigned             cycle_count;
    int unsigned             tx_idle_pct;
    int unsigned             rx_idle_pct;
    int unsigned             hold_seq;
    int unsigned             hold_seen;
    int unsigned             hold_left;

    exchange_sort_integers_core #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_value        (in_value),
        .i_last_in      (in_last),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_sorted_value (out_value),
        .o_last_out     (out_last),
        .o_overflowed   (out_ovf)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("exchange_sort_integers_core: mismatch");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_sorted_item exp_item;
        if (rst_n && out_valid && !out_stall) begin
            if (sorted_q.size() == 0) begin
                $error("unexpected result: sorted_value=%0d last_out=%0b overflowed=%0b",
                       out_value, out_last, out_ovf);
                fail_count++;
            end else begin
                exp_item = sorted_q.pop_front();
                if (out_value !== exp_item.key) begin
                    $error("sorted_value: expected %0d, actual %0d", exp_item.key, out_value);
                    fail_count++;
                end
                if (out_last !== exp_item.last) begin
                    $error("last_out: expected %0b, actual %0b", exp_item.last, out_last);
                    fail_count++;
                end
                if (out_ovf !== exp_item.ovf) begin
                    $error("overflowed: expected %0b, actual %0b", exp_item.ovf, out_ovf);
                    fail_count++;
                end
            end
        end
    end

    task automatic absorb_key(input logic signed [KEY_W-1:0] key, input logic last);
        logic signed [KEY_W-1:0] tmp;
        t_sorted_item            item;
        if (key_count < MAX_ITEMS) begin
            key_store[key_count] = key;
            key_count++;
        end else begin
            key_dropped = 1'b1;
        end
        if (last) begin
            for (int a = 0; a < key_count; a++) begin
                for (int b = a + 1; b < key_count; b++) begin
                    if (key_store[a] > key_store[b]) begin
                        tmp          = key_store[a];
                        key_store[a] = key_store[b];
                        key_store[b] = tmp;
                    end
                end
            end
            for (int k = 0; k < key_count; k++) begin
                item.key  = key_store[k];
                item.last = (k + 1 == key_count);
                item.ovf  = key_dropped;
                sorted_q.push_back(item);
            end
            key_count   = 0;
            key_dropped = 1'b0;
        end
    endtask

    task automatic send_item(input logic signed [KEY_W-1:0] key, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_value <= key;
        in_last  <= last;
        do @(posedge clk); while (in_stall);
        absorb_key(key, last);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(3))
            0:       k = $urandom_range(8) - 4;
            1:       k = 32'h7FFF_FFFF - $urandom_range(2);
            2:       k = 32'h8000_0000 + $urandom_range(2);
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic send_set(input logic signed [KEY_W-1:0] keys [$]);
        for (int i = 0; i < keys.size(); i++) begin
            send_item(keys[i], i == keys.size() - 1);
        end
    endtask

    task automatic test_single_key();
        send_set('{32'sh8000_0000});
        send_set('{32'sh7FFF_FFFF});
        wait_drained();
    endtask

    task automatic test_extremes();
        send_set('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1,
                   32'sh5555_5555, 32'shAAAA_AAAA});
        wait_drained();
    endtask

    task automatic test_equal_keys();
        send_set('{32'sd3, -32'sd3, 32'sd3, 32'sd3, -32'sd3});
        wait_drained();
    endtask

    task automatic test_reverse_order();
        send_set('{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1});
        wait_drained();
    endtask

    task automatic test_store_full();
        for (int i = 0; i < MAX_ITEMS; i++) begin
            send_item(pick_key(), i == MAX_ITEMS - 1);
        end
        wait_drained();
        // last three keys land past capacity and are dropped
        for (int i = 0; i < MAX_ITEMS + 3; i++) begin
            send_item(pick_key(), i == MAX_ITEMS + 2);
        end
        wait_drained();
    endtask

    task automatic test_output_hold();
        int unsigned saved_pct;
        saved_pct   = tx_idle_pct;
        tx_idle_pct = 0;
        hold_seq++;
        for (int s = 0; s < 3; s++) begin
            for (int i = 0; i < 12; i++) begin
                send_item(pick_key(), i == 11);
            end
        end
        tx_idle_pct = saved_pct;
        wait_drained();
    endtask

    task automatic test_random_sets(input int unsigned n_sets);
        int unsigned n_keys;
        for (int s = 0; s < n_sets; s++) begin
            n_keys = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            for (int i = 0; i < n_keys; i++) begin
                send_item(pick_key(), i == n_keys - 1);
            end
            if ($urandom_range(4) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_value    = '0;
        in_last     = 1'b0;
        out_stall   = 1'b0;
        key_count   = 0;
        key_dropped = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        hold_seq    = 0;
        hold_seen   = 0;
        hold_left   = 0;
        tx_idle_pct = 38;
        rx_idle_pct = 75;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_single_key();
        test_extremes();
        test_equal_keys();
        test_reverse_order();
        test_random_sets(2);

        tx_idle_pct = 75;
        rx_idle_pct = 38;
        test_store_full();
        test_output_hold();
        test_random_sets(2);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_sets(2);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && sorted_q.size() == 0) begin
            $display("exchange_sort_integers_core: match");
        end else begin
            $display("exchange_sort_integers_core: mismatch");
        end
        $finish;
    end

endmodule
